@@ sv/shuffled_lehmer_random_generator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator assertion macros
// Clocked, reset-gated property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SLRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slrg port check failed");

// next-cycle implication
`define SLRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slrg port check failed");

`endif

@@ sv/slrg_pkg.sv @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator package
// Shared widths, constants, register map and sequencer states.
// ----------------------------------------------------------------------------
package slrg_pkg;

  localparam int VALUE_W    = 31;
  localparam int MULT_W     = 15;
  localparam int PROD_W     = VALUE_W + MULT_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
  localparam logic [VALUE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;

  // word index of the seed register (paddr[2])
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_MUL,
    ST_INIT_FOLD,
    ST_MUL,
    ST_FOLD,
    ST_DIV,
    ST_READ,
    ST_SWAP
  } state_t;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

@@ sv/slrg_if.sv @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator channels
// Valid/ready word channels for draw requests and drawn values.
// ----------------------------------------------------------------------------
interface slrg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface slrg_out_if;
  logic            valid;
  logic            ready;
  slrg_pkg::value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ sv/slrg_lehmer.sv @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator step unit
// Registered 31x15 multiply by 16807, then Mersenne fold mod 2^31-1.
// ----------------------------------------------------------------------------
module slrg_lehmer (
  input  logic             clk,
  input  slrg_pkg::value_t x_i,
  output slrg_pkg::value_t step_o
);

  logic [slrg_pkg::PROD_W-1:0]  prod_r;
  logic [slrg_pkg::VALUE_W:0]   sum_c;
  logic [slrg_pkg::VALUE_W:0]   mod_ext_c;

  always_ff @(posedge clk) begin
    prod_r <= slrg_pkg::PROD_W'(x_i) * slrg_pkg::PROD_W'(slrg_pkg::LEHMER_MULT);
  end

  // 2^31 == 1 mod M: add the high part back onto the low part
  always_comb begin
    mod_ext_c = {1'b0, slrg_pkg::LEHMER_MOD};
    sum_c = {1'b0, prod_r[slrg_pkg::VALUE_W-1:0]}
          + (slrg_pkg::VALUE_W + 1)'(prod_r[slrg_pkg::PROD_W-1:slrg_pkg::VALUE_W]);
    if (sum_c >= mod_ext_c) begin
      sum_c = sum_c - mod_ext_c;
    end
    step_o = sum_c[slrg_pkg::VALUE_W-1:0];
  end

endmodule

@@ sv/shuffled_lehmer_random_generator_unit.sv @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer random generator unit
// Minimal-standard multiplicative generator with a shuffle table, one draw per word.
// ----------------------------------------------------------------------------
// Plain draw: after accept the sequencer runs MUL, FOLD, DIV, READ and SWAP; the next
//   word is taken after SWAP, later while an earlier result waits unread.
// Initialising draw first runs warm-up steps (INIT_MUL, INIT_FOLD) that fill the table.
// Cost is set by the shared multiply/fold step unit (registered multiply, combinational
//   fold); the slot index is registered in DIV. One draw in flight at a time.
// Reset (synchronous, rst_n low): idle, seed 1, generator uninitialised.
module shuffled_lehmer_random_generator_unit #(
  parameter int TABLE_DEPTH  = 32,
  parameter int WARMUP_EXTRA = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  slrg_in_if.sink                         in_ch,
  slrg_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slrg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [slrg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [slrg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TOTAL  = TABLE_DEPTH + WARMUP_EXTRA;
  localparam int STEP_W = $clog2(TOTAL);
  localparam longint unsigned NDIV = 64'(1 + (2147483646 / TABLE_DEPTH));
  localparam int DIV_SH = 31 + $clog2(NDIV);
  localparam logic [32:0] DIV_RECIP = 33'(((64'd1 << DIV_SH) + NDIV - 64'd1) / NDIV);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  slrg_pkg::state_t state_r, state_nxt;

  slrg_pkg::value_t seed_r;
  slrg_pkg::value_t x_r, x_nxt;
  slrg_pkg::value_t carried_r, carried_nxt;
  slrg_pkg::value_t out_value_r, out_value_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  slrg_pkg::value_t table_mem [TABLE_DEPTH];
  slrg_pkg::value_t rd_q_r;

  slrg_pkg::value_t step_val;
  slrg_pkg::value_t seed_fix;
  logic [63:0]      quot_prod;
  logic [IDX_W-1:0] quot_c;
  logic [IDX_W-1:0] slot_addr;
  logic             we_c;
  logic [IDX_W-1:0] waddr_c;
  slrg_pkg::value_t wdata_c;
  logic             cfg_wr;

  slrg_lehmer u_lehmer (
    .clk    (clk),
    .x_i    (x_r),
    .step_o (step_val)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == slrg_pkg::REG_SEED) ? {1'b0, seed_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 31'd1;
    end else if (cfg_wr && paddr[2] == slrg_pkg::REG_SEED) begin
      seed_r <= pwdata[slrg_pkg::VALUE_W-1:0];
    end
  end

  assign seed_fix = (seed_r == '0 || seed_r == slrg_pkg::LEHMER_MOD) ? 31'd1 : seed_r;
  // slot index by reciprocal multiply, exact for every 31-bit word
  assign quot_prod = 64'(carried_r) * 64'(DIV_RECIP);
  assign quot_c    = quot_prod[DIV_SH +: IDX_W];
  assign slot_addr = (int'(idx_r) >= TABLE_DEPTH) ? IDX_LAST : idx_r;

  assign in_ch.ready  = (state_r == slrg_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    carried_nxt   = carried_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    we_c          = 1'b0;
    waddr_c       = slot_addr;
    wdata_c       = x_r;
    case (state_r)
      slrg_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.restart || carried_r == '0) begin
            x_nxt     = seed_fix;
            step_nxt  = STEP_W'(TOTAL - 1);
            state_nxt = slrg_pkg::ST_INIT_MUL;
          end else begin
            state_nxt = slrg_pkg::ST_MUL;
          end
        end
      end
      slrg_pkg::ST_INIT_MUL: begin
        state_nxt = slrg_pkg::ST_INIT_FOLD;
      end
      slrg_pkg::ST_INIT_FOLD: begin
        x_nxt   = step_val;
        we_c    = (int'(step_r) < TABLE_DEPTH);
        waddr_c = step_r[IDX_W-1:0];
        wdata_c = step_val;
        if (step_r == '0) begin
          carried_nxt = step_val;
          state_nxt   = slrg_pkg::ST_MUL;
        end else begin
          step_nxt  = step_r - 1'b1;
          state_nxt = slrg_pkg::ST_INIT_MUL;
        end
      end
      slrg_pkg::ST_MUL: begin
        state_nxt = slrg_pkg::ST_FOLD;
      end
      slrg_pkg::ST_FOLD: begin
        x_nxt     = step_val;
        state_nxt = slrg_pkg::ST_DIV;
      end
      slrg_pkg::ST_DIV: begin
        idx_nxt   = quot_c;
        state_nxt = slrg_pkg::ST_READ;
      end
      slrg_pkg::ST_READ: begin
        state_nxt = slrg_pkg::ST_SWAP;
      end
      slrg_pkg::ST_SWAP: begin
        if (!out_valid_r || out_ch.ready) begin
          we_c          = 1'b1;
          carried_nxt   = rd_q_r;
          out_value_nxt = rd_q_r;
          out_valid_nxt = 1'b1;
          state_nxt     = slrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slrg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slrg_pkg::ST_IDLE;
      carried_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      carried_r   <= carried_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    idx_r       <= idx_nxt;
    step_r      <= step_nxt;
    out_value_r <= out_value_nxt;
  end

  // shuffle table
  always_ff @(posedge clk) begin
    if (we_c) begin
      table_mem[waddr_c] <= wdata_c;
    end
    rd_q_r <= table_mem[slot_addr];
  end

endmodule

@@ sv/slrg_checker.sv @@
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator port checker
// Port-level properties of the generator, bound onto the top level.
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_random_generator_unit_assert.svh"

module slrg_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input slrg_pkg::value_t out_value
);

  `SLRG_ASSERT_NOW(a_value_range, out_valid, out_value != '0 && out_value != slrg_pkg::LEHMER_MOD)
  `SLRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
  `SLRG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SLRG_ASSERT_NEXT(a_idle_stays_ready, in_ready && !in_valid, in_ready)

endmodule

bind shuffled_lehmer_random_generator_unit slrg_checker u_slrg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);
